### design/sqs_pkg.sv
package sqs_pkg;

    // capacity of the element store
    localparam int DEPTH      = 64;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = IDX_W + 1;

    // disjoint ranges of two or more elements: at most DEPTH/2 on the stack
    localparam int PSTK_DEPTH = DEPTH / 2;
    localparam int PAW        = (PSTK_DEPTH > 1) ? $clog2(PSTK_DEPTH) : 1;
    localparam int SP_W       = PAW + 1;

    typedef logic        [IDX_W-1:0]  idx_t;
    typedef logic        [CNT_W-1:0]  cnt_t;
    typedef logic        [SP_W-1:0]   sp_t;
    typedef logic        [PAW-1:0]    paddr_t;
    typedef logic signed [DATA_W-1:0] elem_t;

    typedef struct packed {
        idx_t lo;
        idx_t hi;
    } range_t;

    localparam int RANGE_W = $bits(range_t);

endpackage

### design/stack_quicksort_lomuto.sv
// Load: one item per cycle; the item flagged last starts the sort.
// Sort: per range, setup in S_POP, S_POPD, S_PIV and S_PIVD; per scanned element
//   S_RD and S_CMP, plus S_SW2 per exchange; S_CMP and S_FIN place the pivot;
//   average O(n log n), worst O(n^2), all set by the single element-store write port.
// Output: registered read, then output register; S_OCAP waits for a held result to go.
// Reset (rst_n, async, low) empties store, stack and overflow flag; no clearing pass.
module stack_quicksort_lomuto (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  sqs_pkg::elem_t  value,
    input  logic            last,
    output logic            out_valid,
    input  logic            out_ready,
    output sqs_pkg::elem_t  sorted_value,
    output logic            final_res,
    output logic            truncated
);
    import sqs_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,   // take items into the store
        S_START,  // push the whole set, if it holds two or more
        S_POP,    // present top of stack
        S_POPD,   // range data back
        S_PIV,    // present pivot address
        S_PIVD,   // capture pivot
        S_RD,     // present a[j], a[place]
        S_CMP,    // compare a[j] with pivot
        S_SW2,    // second half of an exchange
        S_FIN,    // old a[place] to hi, second push
        S_ORD,    // present a[k]
        S_OCAP    // load output register
    } state_t;

    state_t state_reg;
    cnt_t   count_reg;
    sp_t    sp_reg;
    logic   ovf_reg;
    idx_t   lo_reg;
    idx_t   hi_reg;
    idx_t   j_reg;
    idx_t   place_reg;
    idx_t   k_reg;
    elem_t  pivot_reg;
    elem_t  swap_reg;
    logic   out_valid_reg;
    elem_t  sorted_value_reg;
    logic   final_reg;
    logic   trunc_reg;

    // element store, duplicated for two read ports
    logic   e_we;
    idx_t   e_waddr;
    elem_t  e_wdata;
    idx_t   a_raddr;
    idx_t   b_raddr;
    elem_t  rd_a;
    elem_t  rd_b;

    // range stack
    logic   s_we;
    paddr_t s_waddr;
    range_t s_wdata;
    paddr_t s_raddr;
    range_t s_rdata;
    sp_t    sp_m1;

    logic   in_acc;
    logic   room;
    logic   less;
    logic   scan_done;
    logic   stack_room;
    logic   push_lo;
    logic   push_hi;
    logic   last_k;
    logic   out_take;

    assign in_ready   = (state_reg == S_LOAD);
    assign in_acc     = in_valid && in_ready;
    assign room       = (count_reg < cnt_t'(DEPTH));
    assign less       = (rd_a < pivot_reg);
    assign scan_done  = (j_reg == hi_reg);
    assign stack_room = (sp_reg < sp_t'(PSTK_DEPTH));
    // left part lo..place-1 needs sorting if it holds two or more
    assign push_lo    = (cnt_t'(place_reg) > (cnt_t'(lo_reg) + cnt_t'(1))) && stack_room;
    // right part place+1..hi likewise
    assign push_hi    = ((cnt_t'(place_reg) + cnt_t'(1)) < cnt_t'(hi_reg)) && stack_room;
    assign last_k     = ((cnt_t'(k_reg) + cnt_t'(1)) == count_reg);
    assign out_take   = !out_valid_reg || out_ready;
    assign sp_m1      = sp_reg - sp_t'(1);
    assign s_raddr    = sp_m1[PAW-1:0];
    assign b_raddr    = place_reg;

    always_comb
    begin
        if (state_reg == S_PIV)
        begin
            a_raddr = hi_reg;
        end
        else if (state_reg == S_ORD || state_reg == S_OCAP)
        begin
            a_raddr = k_reg;
        end
        else
        begin
            a_raddr = j_reg;
        end
    end

    // element store write port
    always_comb
    begin
        e_we    = 1'b0;
        e_waddr = place_reg;
        e_wdata = rd_a;
        unique case (state_reg)
            S_LOAD:
            begin
                e_we    = in_acc && room;
                e_waddr = count_reg[IDX_W-1:0];
                e_wdata = value;
            end
            S_CMP:
            begin
                if (scan_done)
                begin
                    // pivot moves to its final slot
                    e_we    = 1'b1;
                    e_waddr = place_reg;
                    e_wdata = pivot_reg;
                end
                else if (less)
                begin
                    e_we    = 1'b1;
                    e_waddr = place_reg;
                    e_wdata = rd_a;
                end
            end
            S_SW2:
            begin
                e_we    = 1'b1;
                e_waddr = j_reg;
                e_wdata = swap_reg;
            end
            S_FIN:
            begin
                e_we    = 1'b1;
                e_waddr = hi_reg;
                e_wdata = swap_reg;
            end
            default:
            begin
                e_we = 1'b0;
            end
        endcase
    end

    // range stack write port
    always_comb
    begin
        s_we       = 1'b0;
        s_waddr    = sp_reg[PAW-1:0];
        s_wdata.lo = lo_reg;
        s_wdata.hi = hi_reg;
        unique case (state_reg)
            S_START:
            begin
                s_we       = (count_reg >= cnt_t'(2));
                s_waddr    = '0;
                s_wdata.lo = '0;
                s_wdata.hi = idx_t'(count_reg - cnt_t'(1));
            end
            S_CMP:
            begin
                s_we       = scan_done && push_lo;
                s_wdata.lo = lo_reg;
                s_wdata.hi = place_reg - idx_t'(1);
            end
            S_FIN:
            begin
                s_we       = push_hi;
                s_wdata.lo = place_reg + idx_t'(1);
                s_wdata.hi = hi_reg;
            end
            default:
            begin
                s_we = 1'b0;
            end
        endcase
    end

    sqs_ram #(.AW(IDX_W), .DW(DATA_W)) u_elem_a (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (a_raddr),
        .rdata (rd_a)
    );

    sqs_ram #(.AW(IDX_W), .DW(DATA_W)) u_elem_b (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (b_raddr),
        .rdata (rd_b)
    );

    sqs_ram #(.AW(PAW), .DW(RANGE_W)) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            sp_reg           <= '0;
            ovf_reg          <= 1'b0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            j_reg            <= '0;
            place_reg        <= '0;
            k_reg            <= '0;
            pivot_reg        <= '0;
            swap_reg         <= '0;
            out_valid_reg    <= 1'b0;
            sorted_value_reg <= '0;
            final_reg        <= 1'b0;
            trunc_reg        <= 1'b0;
        end
        else
        begin
            // S_OCAP reloads the output register itself
            if (out_valid_reg && out_ready && state_reg != S_OCAP)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + cnt_t'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;  // store full, item dropped
                        end
                        if (last)
                        begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START:
                begin
                    k_reg <= '0;
                    if (count_reg >= cnt_t'(2))
                    begin
                        sp_reg    <= sp_t'(1);
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        state_reg <= S_ORD;
                    end
                end
                S_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_ORD;
                    end
                    else
                    begin
                        sp_reg    <= sp_m1;
                        state_reg <= S_POPD;
                    end
                end
                S_POPD:
                begin
                    lo_reg <= s_rdata.lo;
                    hi_reg <= s_rdata.hi;
                    if (s_rdata.lo >= s_rdata.hi)
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        state_reg <= S_PIV;
                    end
                end
                S_PIV:
                begin
                    state_reg <= S_PIVD;
                end
                S_PIVD:
                begin
                    pivot_reg <= rd_a;
                    j_reg     <= lo_reg;
                    place_reg <= lo_reg;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (scan_done)
                    begin
                        swap_reg <= rd_b;
                        if (push_lo)
                        begin
                            sp_reg <= sp_reg + sp_t'(1);
                        end
                        state_reg <= S_FIN;
                    end
                    else if (less)
                    begin
                        swap_reg  <= rd_b;
                        state_reg <= S_SW2;
                    end
                    else
                    begin
                        j_reg     <= j_reg + idx_t'(1);
                        state_reg <= S_RD;
                    end
                end
                S_SW2:
                begin
                    place_reg <= place_reg + idx_t'(1);
                    j_reg     <= j_reg + idx_t'(1);
                    state_reg <= S_RD;
                end
                S_FIN:
                begin
                    if (push_hi)
                    begin
                        sp_reg <= sp_reg + sp_t'(1);
                    end
                    state_reg <= S_POP;
                end
                S_ORD:
                begin
                    state_reg <= S_OCAP;
                end
                S_OCAP:
                begin
                    if (out_take)
                    begin
                        out_valid_reg    <= 1'b1;
                        sorted_value_reg <= rd_a;
                        final_reg        <= last_k;
                        trunc_reg        <= ovf_reg;
                        if (last_k)
                        begin
                            // set done; last result may still wait in the output register
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            sp_reg    <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            k_reg     <= k_reg + idx_t'(1);
                            state_reg <= S_ORD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign final_res    = final_reg;
    assign truncated    = trunc_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= sp_t'(PSTK_DEPTH))
        else $error("range stack overrun");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cnt_t'(DEPTH))
        else $error("element count beyond capacity");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (lo_reg <= place_reg && place_reg <= j_reg && j_reg <= hi_reg))
        else $error("partition indexes out of order");

    a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OCAP && out_take && last_k)
        |=> (state_reg == S_LOAD && count_reg == '0 && out_valid_reg && final_reg))
        else $error("set not closed after final result");

endmodule

### design/sqs_ram.sv
module sqs_ram #(
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
